// ===== src/arith_expression_tokenizer_defines.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef ARITH_EXPRESSION_TOKENIZER_DEFINES_SVH
`define ARITH_EXPRESSION_TOKENIZER_DEFINES_SVH

// Checked at every edge, reset included.
`define AET_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define AET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/aet_pkg.sv =====
`timescale 1ns / 1ps
package aet_pkg;

    typedef enum logic [3:0] {
        KIND_INT     = 4'd0,
        KIND_FLOAT   = 4'd1,
        KIND_ADD     = 4'd2,
        KIND_SUB     = 4'd3,
        KIND_MUL     = 4'd4,
        KIND_DIV     = 4'd5,
        KIND_MOD     = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_UNKNOWN = 4'd9,
        KIND_END     = 4'd10
    } token_kind_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  ch;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } token_t;

    // Status of the output queue seen by the top level.
    typedef struct packed {
        logic       head_valid;
        logic       room;
        logic [1:0] count;
    } queue_status_t;

endpackage

// ===== src/aet_lexer.sv =====
`timescale 1ns / 1ps
module aet_lexer
    import aet_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] source_byte,
    output token_t     tok0,
    output token_t     tok1,
    output logic [1:0] tok_count
);

    localparam int PB = POSITION_BITS;
    localparam int WW = POSITION_BITS + 16;

    typedef enum logic [2:0] {
        SCAN_IDLE = 3'b001,
        SCAN_INT  = 3'b010,
        SCAN_FRAC = 3'b100
    } scan_mode_t;

    scan_mode_t    mode_reg, mode_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] line_reg, line_next;
    logic [PB-1:0] col_reg, col_next;
    logic [PB-1:0] nstart_reg, nstart_next;
    logic [PB-1:0] nline_reg, nline_next;
    logic [PB-1:0] ncol_reg, ncol_next;
    logic [7:0]    nchar_reg, nchar_next;

    logic [PB-1:0] step_pos, step_line, step_col, num_len;
    logic          num_open, is_digit, is_space, is_dot, cont, emit_num, has_second;
    token_t        num_tok, second_tok;
    token_kind_t   op_kind;

    function automatic logic [15:0] clamp16(input logic [PB-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        if (w > WW'(16'hFFFF))
            return 16'hFFFF;
        return w[15:0];
    endfunction

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        if (v == {PB{1'b1}})
            return v;
        return v + PB'(1);
    endfunction

    assign is_digit = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
    assign is_space = (source_byte == CH_SPACE)
                   || ((source_byte >= CH_TAB) && (source_byte <= CH_CR));
    assign is_dot   = (source_byte == CH_DOT);

    always_comb
    begin
        unique case (mode_reg)
            SCAN_IDLE: num_open = 1'b0;
            SCAN_INT:  num_open = 1'b1;
            SCAN_FRAC: num_open = 1'b1;
            default:   num_open = 1'b1;
        endcase
    end

    assign cont       = num_open && (is_digit || (is_dot && mode_reg == SCAN_INT));
    assign emit_num   = num_open && !cont;
    assign has_second = !cont && !is_space && !is_digit;

    // Position counters after this byte
    assign step_pos  = sat_inc(pos_reg);
    assign step_line = (source_byte == CH_NEWLINE) ? sat_inc(line_reg) : line_reg;
    assign step_col  = (source_byte == CH_NEWLINE) ? PB'(1) : sat_inc(col_reg);

    assign num_len = (pos_reg >= nstart_reg) ? pos_reg - nstart_reg : '0;

    always_comb
    begin
        unique case (source_byte)
            CH_PLUS:    op_kind = KIND_ADD;
            CH_MINUS:   op_kind = KIND_SUB;
            CH_STAR:    op_kind = KIND_MUL;
            CH_SLASH:   op_kind = KIND_DIV;
            CH_PERCENT: op_kind = KIND_MOD;
            CH_LPAREN:  op_kind = KIND_LPAREN;
            CH_RPAREN:  op_kind = KIND_RPAREN;
            CH_NUL:     op_kind = KIND_END;
            default:    op_kind = KIND_UNKNOWN;
        endcase
    end

    always_comb
    begin
        num_tok.kind   = (mode_reg == SCAN_INT) ? KIND_INT : KIND_FLOAT;
        num_tok.start  = clamp16(nstart_reg);
        num_tok.length = clamp16(num_len);
        num_tok.ch     = nchar_reg;
        num_tok.line   = clamp16(nline_reg);
        num_tok.column = clamp16(ncol_reg);
        num_tok.last   = 1'b0;

        second_tok.kind   = op_kind;
        second_tok.start  = clamp16(pos_reg);
        second_tok.length = (source_byte == CH_NUL) ? 16'd0 : 16'd1;
        second_tok.ch     = source_byte;
        second_tok.line   = clamp16(line_reg);
        second_tok.column = clamp16(col_reg);
        second_tok.last   = 1'b1;

        tok_count = {1'b0, emit_num} + {1'b0, has_second};
        tok0      = emit_num ? num_tok : second_tok;
        tok0.last = (tok_count == 2'd1);
        tok1      = second_tok;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = step_pos;
        line_next   = step_line;
        col_next    = step_col;
        nstart_next = nstart_reg;
        nline_next  = nline_reg;
        ncol_next   = ncol_reg;
        nchar_next  = nchar_reg;
        if (cont)
        begin
            if (is_dot)
                mode_next = SCAN_FRAC;
        end
        else if (source_byte == CH_NUL)
        begin
            // End of text: restart everything
            mode_next   = SCAN_IDLE;
            pos_next    = '0;
            line_next   = PB'(1);
            col_next    = PB'(1);
            nstart_next = '0;
            nline_next  = PB'(1);
            ncol_next   = PB'(1);
            nchar_next  = CH_NUL;
        end
        else if (is_digit)
        begin
            mode_next   = SCAN_INT;
            nstart_next = pos_reg;
            nline_next  = line_reg;
            ncol_next   = col_reg;
            nchar_next  = source_byte;
        end
        else
        begin
            mode_next = SCAN_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= SCAN_IDLE;
            pos_reg    <= '0;
            line_reg   <= PB'(1);
            col_reg    <= PB'(1);
            nstart_reg <= '0;
            nline_reg  <= PB'(1);
            ncol_reg   <= PB'(1);
            nchar_reg  <= CH_NUL;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            nstart_reg <= nstart_next;
            nline_reg  <= nline_next;
            ncol_reg   <= ncol_next;
            nchar_reg  <= nchar_next;
        end
    end

endmodule

// ===== src/aet_token_queue.sv =====
`timescale 1ns / 1ps
module aet_token_queue
    import aet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [1:0]    push_count,
    input  token_t        push_tok0,
    input  token_t        push_tok1,
    input  logic          pop,
    output token_t        head,
    output queue_status_t status
);

    token_t     slot0_reg, slot1_reg;
    logic [1:0] count_reg, count_next, remain;

    assign remain      = count_reg - {1'b0, pop};
    assign count_next  = push ? remain + push_count : remain;

    assign head              = slot0_reg;
    assign status.head_valid = (count_reg != 2'd0);
    assign status.room       = (remain == 2'd0);
    assign status.count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Words enter only into a queue that is empty after this cycle's pop; a full queue advances slot1 on pop.
    always_ff @(posedge clk)
    begin
        if (push && remain == 2'd0)
        begin
            slot0_reg <= push_tok0;
            slot1_reg <= push_tok1;
        end
        else if (pop && count_reg == 2'd2)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== src/arith_expression_tokenizer.sv =====
`timescale 1ns / 1ps
// Arithmetic expression tokenizer.
// Input channel: source_byte with source_valid / source_stall, one text byte per word.
// A byte of 0 closes the text: any open number comes out, then an end token,
// and position, line and column restart.
// Output channel: one token per word on the token_* ports with token_valid /
// token_stall; last marks the final token caused by an input byte.
// A taken byte goes into the input register, is then lexed into the
// two-entry queue, and the queue head is offered as the token.
// Throughput: one byte per cycle while the receiver does not stall. A byte
// that ends a number and also gives a token yields two words, and the input
// then stalls until the single output port has drained the queue.
// Whitespace and digits inside a number give no word.
// When the receiver stalls, the head token holds, the queue is not emptied,
// and the input register then raises source_stall until room opens.
// Reset clears the input register, the queue and the lexer state
// (position 0, line 1, column 1).
`include "arith_expression_tokenizer_defines.svh"
module arith_expression_tokenizer
    import aet_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_valid,
    output logic        source_stall,
    input  logic [7:0]  source_byte,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [7:0]  token_char,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic        last
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          lex_go, pop;
    token_t        tok0, tok1, head;
    logic [1:0]    tok_count;
    queue_status_t q_status;
    logic          end_out, end_ok, single_out, single_ok;

    assign lex_go       = in_valid_reg && q_status.room;
    assign source_stall = in_valid_reg && !q_status.room;
    assign pop          = token_valid && !token_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!source_stall)
            in_valid_reg <= source_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!source_stall)
            in_byte_reg <= source_byte;
    end

    aet_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (lex_go),
        .source_byte(in_byte_reg),
        .tok0       (tok0),
        .tok1       (tok1),
        .tok_count  (tok_count)
    );

    aet_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lex_go),
        .push_count(tok_count),
        .push_tok0 (tok0),
        .push_tok1 (tok1),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    assign token_valid  = q_status.head_valid;
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign token_char   = head.ch;
    assign token_line   = head.line;
    assign token_column = head.column;
    assign last         = head.last;

    assign end_out    = token_valid && (token_kind == KIND_END);
    assign end_ok     = (token_length == 16'd0) && (token_char == CH_NUL) && last;
    assign single_out = token_valid && (token_kind != KIND_END) && (token_kind != KIND_INT)
                     && (token_kind != KIND_FLOAT);
    assign single_ok  = (token_length == 16'd1) && last;

    `AET_ASSERT_ALWAYS(a_queue_no_overflow, !rst_n || q_status.count != 2'd3, "queue overflow")
    `AET_ASSERT(a_lex_only_with_room, lex_go |-> (q_status.count == 2'd0 || pop), "busy queue")
    `AET_ASSERT(a_end_token_empty, end_out |-> end_ok, "bad end token")
    `AET_ASSERT(a_single_char_len, single_out |-> single_ok, "bad single character token")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import aet_pkg::*;

    localparam int RUN_LIMIT_NS  = 1_000_000;
    localparam int DRAIN_LIMIT   = 10_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        SCAN_OUTSIDE,
        SCAN_WHOLE,
        SCAN_FRACTION
    } scan_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        source_valid = 1'b0;
    logic        source_stall;
    logic [7:0]  source_byte = 8'h00;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  token_char;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last;

    // lexer state mirrored by the testbench
    scan_mode_t  scan;
    logic [15:0] cur_pos;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] num_pos;
    logic [15:0] num_line;
    logic [15:0] num_col;
    logic [7:0]  num_char;

    token_t pending_tokens[$];

    int src_idle_pct = 0;
    int rcv_stall_pct = 0;
    int bytes_sent = 0;
    int tokens_checked = 0;
    int end_tokens_seen = 0;
    int number_tokens_seen = 0;
    int mismatches = 0;

    arith_expression_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_stall (source_stall),
        .source_byte  (source_byte),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_char   (token_char),
        .token_line   (token_line),
        .token_column (token_column),
        .last         (last)
    );

    always #4 clk = ~clk;

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Timed out at %0t", $time);
        $display("** arith_expression_tokenizer: FAILED **");
        $finish;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic token_t pack_token(input token_kind_t kind, input logic [15:0] pos,
                                          input logic [15:0] len, input logic [7:0] ch,
                                          input logic [15:0] line, input logic [15:0] col);
        token_t t;
        t.kind   = kind;
        t.start  = pos;
        t.length = len;
        t.ch     = ch;
        t.line   = line;
        t.column = col;
        t.last   = 1'b0;
        return t;
    endfunction

    task automatic restart_lexer();
        scan     = SCAN_OUTSIDE;
        cur_pos  = 16'd0;
        cur_line = 16'd1;
        cur_col  = 16'd1;
        num_pos  = 16'd0;
        num_line = 16'd1;
        num_col  = 16'd1;
        num_char = 8'h00;
    endtask

    task automatic advance_position(input logic [7:0] c);
        if (c == CH_NEWLINE)
        begin
            cur_line = sat_inc(cur_line);
            cur_col  = 16'd1;
        end
        else
        begin
            cur_col = sat_inc(cur_col);
        end
        cur_pos = sat_inc(cur_pos);
    endtask

    // Work out the tokens that one accepted byte produces and queue them.
    task automatic lex_byte(input logic [7:0] c);
        token_t      toks [2];
        token_kind_t kind;
        int          n;
        n = 0;
        if (scan != SCAN_OUTSIDE && (is_digit(c) || (c == CH_DOT && scan == SCAN_WHOLE)))
        begin
            if (c == CH_DOT)
                scan = SCAN_FRACTION;
            advance_position(c);
        end
        else
        begin
            if (scan != SCAN_OUTSIDE)
            begin
                toks[n] = pack_token((scan == SCAN_WHOLE) ? KIND_INT : KIND_FLOAT, num_pos,
                                     cur_pos - num_pos, num_char, num_line, num_col);
                n++;
                scan = SCAN_OUTSIDE;
            end
            if (c == CH_NUL)
            begin
                toks[n] = pack_token(KIND_END, cur_pos, 16'd0, CH_NUL, cur_line, cur_col);
                n++;
                restart_lexer();
            end
            else if (is_space(c))
            begin
                advance_position(c);
            end
            else if (is_digit(c))
            begin
                scan     = SCAN_WHOLE;
                num_pos  = cur_pos;
                num_line = cur_line;
                num_col  = cur_col;
                num_char = c;
                advance_position(c);
            end
            else
            begin
                case (c)
                    CH_PLUS:   kind = KIND_ADD;
                    CH_MINUS:  kind = KIND_SUB;
                    CH_STAR:   kind = KIND_MUL;
                    CH_SLASH:  kind = KIND_DIV;
                    CH_PERCENT: kind = KIND_MOD;
                    CH_LPAREN: kind = KIND_LPAREN;
                    CH_RPAREN: kind = KIND_RPAREN;
                    default:   kind = KIND_UNKNOWN;
                endcase
                toks[n] = pack_token(kind, cur_pos, 16'd1, c, cur_line, cur_col);
                n++;
                advance_position(c);
            end
            if (n > 0)
                toks[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++)
                pending_tokens.push_back(toks[i]);
        end
    endtask

    // Offer one byte, hold it until taken, then update the mirror.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            source_valid <= 1'b0;
            @(posedge clk);
        end
        source_valid <= 1'b1;
        source_byte  <= c;
        @(posedge clk);
        while (source_stall)
            @(posedge clk);
        lex_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                         $time, token_kind, token_start);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                report_field("token_kind", want.kind, token_kind);
                report_field("token_start", want.start, token_start);
                report_field("token_length", want.length, token_length);
                report_field("token_char", want.ch, token_char);
                report_field("token_line", want.line, token_line);
                report_field("token_column", want.column, token_column);
                report_field("last", want.last, last);
                tokens_checked++;
                if (want.kind == KIND_END)
                    end_tokens_seen++;
                if (want.kind == KIND_INT || want.kind == KIND_FLOAT)
                    number_tokens_seen++;
            end
        end
        token_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(6))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PERCENT;
            5:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(3) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // Mostly well-formed expression pieces, with some noise mixed in.
    task automatic send_random_lexeme();
        int pick;
        int count;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++)
                send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            if ($urandom_range(1) == 1)
            begin
                send_byte(CH_DOT);
                count = $urandom_range(0, 4);
                for (int i = 0; i < count; i++)
                    send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
                if ($urandom_range(9) == 0)
                    send_byte(CH_DOT);
            end
        end
        else if (pick < 62)
        begin
            send_byte(pick_operator());
        end
        else if (pick < 78)
        begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++)
                send_byte(pick_space());
        end
        else if (pick < 83)
        begin
            send_byte(CH_NUL);
        end
        else
        begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_expression();
        // ints, a float, a second dot, a trailing-dot float, every operator,
        // all whitespace kinds, byte extremes and a number closed by end of text
        send_text("(12+3.5)*7..9 %/-\n\t");
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(CH_CR);
        send_byte(CH_ZERO);
        send_byte(CH_NUL);
    endtask

    task automatic test_random_text(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_lexeme();
    endtask

    task automatic test_drain_pause();
        source_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    task automatic wait_for_drain();
        int cycles;
        cycles = 0;
        source_valid <= 1'b0;
        while (pending_tokens.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $display("%0t: %0d tokens never arrived: expected 0 left, got %0d",
                     $time, pending_tokens.size(), pending_tokens.size());
            mismatches += pending_tokens.size();
        end
    endtask

    initial
    begin
        restart_lexer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 38;
        rcv_stall_pct = 79;
        test_directed_expression();
        test_random_text(510);
        test_drain_pause();

        src_idle_pct  = 79;
        rcv_stall_pct = 38;
        test_random_text(510);
        test_drain_pause();

        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_random_text(510);

        wait_for_drain();
        $display("Sent %0d source bytes; checked %0d tokens (%0d numbers, %0d end of text)",
                 bytes_sent, tokens_checked, number_tokens_seen, end_tokens_seen);
        $display("Included idle and stall mixes, a full drain pause and back to back bytes");
        if (mismatches == 0)
            $display("** arith_expression_tokenizer: PASSED **");
        else
            $display("** arith_expression_tokenizer: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/aet_pkg.sv
src/aet_lexer.sv
src/aet_token_queue.sv
src/arith_expression_tokenizer.sv
tb/tb_top.sv
